// File: rtl/core/fbrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrc_pkg
// Types and constants shared by the framed byte receiver and its channels.
// ----------------------------------------------------------------------------
package fbrc_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LEN_W      = 6;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CAP_DEPTH  = 5;
   localparam int unsigned CAP_IDX_W  = 3;

   localparam logic [BYTE_W-1:0]    TAIL_BYTE   = 8'h55;
   localparam logic [LEN_W-1:0]     STD_PAYLOAD = 6'd5;
   localparam logic [CAP_IDX_W-1:0] CAP_LAST    = 3'd5;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HEADER  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_HEADER = 8'd1;

   typedef enum logic [2:0] {
      PH_HEAD1 = 3'd0,
      PH_HEAD2 = 3'd1,
      PH_LEN   = 3'd2,
      PH_DATA  = 3'd3,
      PH_CHK   = 3'd4,
      PH_TAIL  = 3'd5
   } phase_type;

endpackage

// File: rtl/core/fbrc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrc_req_if
// Received byte channel: valid, ready and one byte.
// ----------------------------------------------------------------------------
interface fbrc_req_if;
   import fbrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/fbrc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrc_rsp_if
// Frame result channel: valid, ready and the frame report.
// ----------------------------------------------------------------------------
interface fbrc_rsp_if;
   import fbrc_pkg::*;

   logic              valid;
   logic              ready;
   logic [LEN_W-1:0]  frame_length;
   logic              format_ok;
   logic              checksum_ok;
   logic [WORD_W-1:0] target_x;
   logic [WORD_W-1:0] target_y;
   logic [BYTE_W-1:0] target_flag;

   modport source (output valid, output frame_length, output format_ok,
                   output checksum_ok, output target_x, output target_y,
                   output target_flag, input ready);
   modport sink   (input valid, input frame_length, input format_ok,
                   input checksum_ok, input target_x, input target_y,
                   input target_flag, output ready);
endinterface

// File: rtl/core/fbrc_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbrc_csr_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface fbrc_csr_if;
   import fbrc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [BYTE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/framed_byte_receiver_checksum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_byte_receiver_checksum
// Finds frames of header, header, length, payload, checksum and tail bytes
// in a byte stream and reports each completed frame.
// ----------------------------------------------------------------------------
// Usage:
//   req  carries one received byte per transaction.
//   rsp  carries one frame report per accepted tail byte; other bytes give
//        no transaction.
//   csr  writes the two header bytes (index 0 and 1); it is always ready and
//        should be used only while the receiver is idle.
// Timing:
//   Each byte is parsed in the cycle it is accepted; the report appears on
//   rsp in the cycle after the tail byte is accepted. One byte can be accepted
//   every cycle while no report waits on a stalled rsp, the rate being set by
//   the single parse stage and the rsp output register.
// Reset:
//   Synchronous reset returns the parser to waiting for the first header and
//   clears the headers, running sum and held x, y and flag values.
// Back-pressure:
//   While a report waits on rsp and rsp.ready is low, req.ready is low; a
//   report is never dropped or repeated.
// ----------------------------------------------------------------------------
module framed_byte_receiver_checksum #(
   parameter int unsigned LEN_LIMIT = 40
) (
   input logic        clock,
   input logic        reset,
   fbrc_req_if.sink   req,
   fbrc_rsp_if.source rsp,
   fbrc_csr_if.sink   csr
);
   import fbrc_pkg::*;

   localparam logic [BYTE_W:0] LenLimitW = (BYTE_W+1)'(LEN_LIMIT);

   phase_type             phase_ff, phase_in;
   logic [BYTE_W-1:0]     head1_ff, head2_ff;
   logic [LEN_W-1:0]      remaining_ff, remaining_in;
   logic [LEN_W-1:0]      frame_len_ff, frame_len_in;
   logic [CAP_IDX_W-1:0]  cap_idx_ff, cap_idx_in;
   logic [BYTE_W-1:0]     sum_ff, sum_in;
   logic [BYTE_W-1:0]     chk_ff, chk_in;
   logic [BYTE_W-1:0]     capture_ff [CAP_DEPTH];
   logic                  cap_wr;
   logic [WORD_W-1:0]     held_x_ff, held_x_in;
   logic [WORD_W-1:0]     held_y_ff, held_y_in;
   logic [BYTE_W-1:0]     held_flag_ff, held_flag_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]      rsp_len_ff;
   logic                  rsp_fmt_ff, rsp_sum_ff;
   logic [WORD_W-1:0]     rsp_x_ff, rsp_y_ff;
   logic [BYTE_W-1:0]     rsp_flag_ff;

   logic                  req_fire;
   logic [BYTE_W-1:0]     b;
   logic                  tail_hit, fmt_ok, sum_ok;

   assign b         = req.rx_byte;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign tail_hit = (phase_ff == PH_TAIL) && (b == TAIL_BYTE);
   assign fmt_ok   = (frame_len_ff == STD_PAYLOAD);
   assign sum_ok   = fmt_ok && (sum_ff == chk_ff);

   // Next phase: any byte that does not fit the current phase drops back to
   // waiting for the first header without being looked at again.
   always_comb begin
      phase_in = PH_HEAD1;
      unique case (phase_ff)
         PH_HEAD1: if (b == head1_ff) phase_in = PH_HEAD2;
         PH_HEAD2: if (b == head2_ff) phase_in = PH_LEN;
         PH_LEN:   if ({1'b0, b} < LenLimitW) phase_in = PH_DATA;
         PH_DATA: begin
            if (remaining_ff == LEN_W'(1))      phase_in = PH_CHK;
            else if (remaining_ff != '0)        phase_in = PH_DATA;
         end
         PH_CHK:   phase_in = PH_TAIL;
         PH_TAIL:  phase_in = PH_HEAD1;
         default:  phase_in = PH_HEAD1;
      endcase
   end

   // Datapath updates for the accepted byte.
   always_comb begin
      remaining_in = remaining_ff;
      frame_len_in = frame_len_ff;
      cap_idx_in   = '0;
      sum_in       = sum_ff;
      chk_in       = chk_ff;
      cap_wr       = 1'b0;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      held_flag_in = held_flag_ff;
      unique case (phase_ff)
         PH_HEAD1: if (b == head1_ff) sum_in = b;
         PH_HEAD2: if (b == head2_ff) sum_in = sum_ff + b;
         PH_LEN: begin
            if ({1'b0, b} < LenLimitW) begin
               remaining_in = b[LEN_W-1:0];
               frame_len_in = b[LEN_W-1:0];
               sum_in       = sum_ff + b;
            end
         end
         PH_DATA: begin
            if (remaining_ff != '0) begin
               remaining_in = remaining_ff - LEN_W'(1);
               sum_in       = sum_ff + b;
               cap_wr       = (cap_idx_ff != CAP_LAST);
               // The index saturates once all captured bytes are in.
               cap_idx_in   = cap_wr ? cap_idx_ff + CAP_IDX_W'(1) : cap_idx_ff;
            end
         end
         PH_CHK: begin
            chk_in     = b;
            cap_idx_in = cap_idx_ff;
         end
         PH_TAIL: begin
            if (tail_hit && sum_ok) begin
               held_x_in    = {capture_ff[0], capture_ff[1]};
               held_y_in    = {capture_ff[2], capture_ff[3]};
               held_flag_in = capture_ff[4];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (req_fire && tail_hit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD1;
         head1_ff     <= '0;
         head2_ff     <= '0;
         remaining_ff <= '0;
         frame_len_ff <= '0;
         cap_idx_ff   <= '0;
         sum_ff       <= '0;
         chk_ff       <= '0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         held_flag_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            if (csr.index == CSR_FIRST_HEADER)  head1_ff <= csr.data;
            if (csr.index == CSR_SECOND_HEADER) head2_ff <= csr.data;
         end
         if (req_fire) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
            frame_len_ff <= frame_len_in;
            cap_idx_ff   <= cap_idx_in;
            sum_ff       <= sum_in;
            chk_ff       <= chk_in;
            held_x_ff    <= held_x_in;
            held_y_ff    <= held_y_in;
            held_flag_ff <= held_flag_in;
         end
      end
   end

   // Capture store and report register hold payload only.
   always_ff @(posedge clock) begin
      if (req_fire && cap_wr) capture_ff[cap_idx_ff] <= b;
      if (req_fire && tail_hit) begin
         rsp_len_ff  <= frame_len_ff;
         rsp_fmt_ff  <= fmt_ok;
         rsp_sum_ff  <= sum_ok;
         rsp_x_ff    <= held_x_in;
         rsp_y_ff    <= held_y_in;
         rsp_flag_ff <= held_flag_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.frame_length = rsp_len_ff;
   assign rsp.format_ok    = rsp_fmt_ff;
   assign rsp.checksum_ok  = rsp_sum_ff;
   assign rsp.target_x     = rsp_x_ff;
   assign rsp.target_y     = rsp_y_ff;
   assign rsp.target_flag  = rsp_flag_ff;

   a_tail_reports: assert property (@(posedge clock) disable iff (reset)
      (req_fire && tail_hit) |=> rsp_valid_ff)
      else $error("accepted tail byte gave no report");

   a_tail_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff == PH_TAIL) |=> (phase_ff == PH_HEAD1))
      else $error("parser did not return to idle after the tail phase");

   a_sum_needs_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_sum_ff || (rsp_fmt_ff && rsp_len_ff == STD_PAYLOAD)))
      else $error("checksum reported good on a frame of the wrong length");

   a_no_report_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_ff != PH_TAIL && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("report raised by a byte other than the tail");

endmodule
